FILE: rtl/hilbert_3d_transpose_defines.svh
// Assertion macros used by the top level of the three-axis curve transform.
`ifndef HILBERT_3D_TRANSPOSE_DEFINES_SVH
`define HILBERT_3D_TRANSPOSE_DEFINES_SVH

`ifndef SYNTHESIS

`define H3DT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("h3dt check failed");

`define H3DT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("h3dt check failed");

`else

`define H3DT_ASSERT(lbl, clk, rst_n, prop)

`define H3DT_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

FILE: rtl/h3dt_pkg.sv
// Types, constants and word functions of the three-axis curve transform.
`timescale 1ns / 1ps

package h3dt_pkg;

  localparam int COORD_BITS = 8;
  localparam int AXES       = 3;
  localparam int CFG_W      = 4;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [CFG_W-1:0] BITS_RESET = CFG_W'(8);

  typedef enum logic [0:0] {
    REG_BITS_IN_USE = 1'b0,
    REG_NONE        = 1'b1
  } reg_idx_e;

  typedef enum logic [0:0] {
    ACT_TO_AXES      = 1'b0,
    ACT_TO_TRANSPOSE = 1'b1
  } action_e;

  typedef logic [COORD_BITS-1:0] word_t;
  typedef word_t [AXES-1:0] triple_t;

  typedef struct packed {
    logic  action;
    word_t coord_x;
    word_t coord_y;
    word_t coord_z;
  } cmd_t;

  typedef struct packed {
    word_t out_x;
    word_t out_y;
    word_t out_z;
  } res_t;

  typedef struct packed {
    logic    action;
    triple_t w;
  } work_t;

  function automatic triple_t level_step(triple_t w, logic [1:0] axis, word_t q);
    triple_t r;
    word_t   p;
    word_t   d;
    r = w;
    p = q - word_t'(1);
    if ((r[axis] & q) != '0) begin
      r[0] = r[0] ^ p;
    end else begin
      d       = (r[0] ^ r[axis]) & p;
      r[0]    = r[0] ^ d;
      r[axis] = r[axis] ^ d;
    end
    return r;
  endfunction

  function automatic triple_t rot_fwd(triple_t t);
    triple_t r;
    r[0] = t[1];
    r[1] = t[2];
    r[2] = t[0];
    return r;
  endfunction

  function automatic triple_t rot_bwd(triple_t t);
    triple_t r;
    r[0] = t[2];
    r[1] = t[0];
    r[2] = t[1];
    return r;
  endfunction

  // Levels above the word width each rotate the three words; only the count modulo three matters.
  function automatic logic [1:0] rot_amount(logic [CFG_W-1:0] b);
    logic [CFG_W:0] n;
    n = '0;
    if (int'(b) > COORD_BITS) begin
      n = (CFG_W+1)'(int'(b) - COORD_BITS);
    end
    for (int i = 0; i < 5; i++) begin
      if (n >= (CFG_W+1)'(3)) begin
        n = n - (CFG_W+1)'(3);
      end
    end
    return n[1:0];
  endfunction

endpackage

FILE: rtl/h3dt_cfg.sv
// Configuration register port holding the bit level count.
`timescale 1ns / 1ps

module h3dt_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [h3dt_pkg::ADDR_W-1:0] paddr,
  input  logic [h3dt_pkg::DATA_W-1:0] pwdata,
  output logic [h3dt_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output logic [h3dt_pkg::CFG_W-1:0]  levels_o
);

  logic [h3dt_pkg::CFG_W-1:0] bits_q;
  logic [h3dt_pkg::CFG_W-1:0] bits_d;
  h3dt_pkg::reg_idx_e         reg_idx;

  assign reg_idx = h3dt_pkg::reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    bits_d = bits_q;
    if (psel && penable && pwrite && pready && reg_idx == h3dt_pkg::REG_BITS_IN_USE) begin
      bits_d = pwdata[h3dt_pkg::CFG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= h3dt_pkg::BITS_RESET;
    end else begin
      bits_q <= bits_d;
    end
  end

  always_comb begin
    case (reg_idx)
      h3dt_pkg::REG_BITS_IN_USE: prdata = h3dt_pkg::DATA_W'(bits_q);
      default:                   prdata = '0;
    endcase
  end

  // A count of zero behaves as a count of one.
  assign levels_o = (bits_q == '0) ? h3dt_pkg::CFG_W'(1) : bits_q;

endmodule

FILE: rtl/h3dt_pre.sv
// Entry stage: Gray decode or the rotation of levels above the word width.
`timescale 1ns / 1ps

module h3dt_pre (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  h3dt_pkg::cmd_t             cmd_i,
  input  logic [h3dt_pkg::CFG_W-1:0] levels_i,
  output logic                       valid_o,
  output h3dt_pkg::work_t            data_o
);

  logic                     valid_q;
  h3dt_pkg::work_t          data_q;
  h3dt_pkg::work_t          data_d;
  h3dt_pkg::triple_t        w;
  logic [1:0]               rot;

  always_comb begin
    w[0] = cmd_i.coord_x;
    w[1] = cmd_i.coord_y;
    w[2] = cmd_i.coord_z;
    rot  = h3dt_pkg::rot_amount(levels_i);
    data_d.action = cmd_i.action;
    data_d.w      = w;
    if (h3dt_pkg::action_e'(cmd_i.action) == h3dt_pkg::ACT_TO_AXES) begin
      data_d.w[2] = w[2] ^ w[1];
      data_d.w[1] = w[1] ^ w[0];
      data_d.w[0] = w[0] ^ (w[2] >> 1);
    end else begin
      case (rot)
        2'd1:    data_d.w = h3dt_pkg::rot_bwd(w);
        2'd2:    data_d.w = h3dt_pkg::rot_fwd(w);
        default: data_d.w = w;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/h3dt_level.sv
// One bit level of the transform, used ascending or descending by direction.
`timescale 1ns / 1ps

module h3dt_level #(
  parameter int LEVEL = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  h3dt_pkg::work_t            data_i,
  input  logic [h3dt_pkg::CFG_W-1:0] levels_i,
  output logic                       valid_o,
  output h3dt_pkg::work_t            data_o
);

  localparam int              LvlUp = LEVEL + 1;
  localparam int              LvlDn = h3dt_pkg::COORD_BITS - 1 - LEVEL;
  localparam h3dt_pkg::word_t QUp   = h3dt_pkg::word_t'(1) << LvlUp;
  localparam h3dt_pkg::word_t QDn   = h3dt_pkg::word_t'(1) << LvlDn;

  logic            valid_q;
  h3dt_pkg::work_t data_q;
  h3dt_pkg::work_t data_d;
  logic            to_axes;
  logic            active;

  always_comb begin
    to_axes = (h3dt_pkg::action_e'(data_i.action) == h3dt_pkg::ACT_TO_AXES);
    if (to_axes) begin
      active = ({1'b0, levels_i} > (h3dt_pkg::CFG_W+1)'(LvlUp));
    end else begin
      active = ({1'b0, levels_i} > (h3dt_pkg::CFG_W+1)'(LvlDn));
    end
    data_d = data_i;
    if (active) begin
      if (to_axes) begin
        for (int i = h3dt_pkg::AXES - 1; i >= 0; i--) begin
          data_d.w = h3dt_pkg::level_step(data_d.w, 2'(i), QUp);
        end
      end else begin
        for (int i = 0; i < h3dt_pkg::AXES; i++) begin
          data_d.w = h3dt_pkg::level_step(data_d.w, 2'(i), QDn);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: rtl/h3dt_post.sv
// Exit stage: rotation of levels above the word width or Gray encode.
`timescale 1ns / 1ps

module h3dt_post (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  h3dt_pkg::work_t            data_i,
  input  logic [h3dt_pkg::CFG_W-1:0] levels_i,
  output logic                       valid_o,
  output h3dt_pkg::res_t             result_o
);

  logic              valid_q;
  h3dt_pkg::res_t    res_q;
  h3dt_pkg::res_t    res_d;
  h3dt_pkg::triple_t w;
  h3dt_pkg::word_t   g;
  logic [1:0]        rot;

  always_comb begin
    rot = h3dt_pkg::rot_amount(levels_i);
    w   = data_i.w;
    g   = '0;
    if (h3dt_pkg::action_e'(data_i.action) == h3dt_pkg::ACT_TO_AXES) begin
      case (rot)
        2'd1:    w = h3dt_pkg::rot_fwd(data_i.w);
        2'd2:    w = h3dt_pkg::rot_bwd(data_i.w);
        default: w = data_i.w;
      endcase
    end else begin
      w[1] = w[1] ^ w[0];
      w[2] = w[2] ^ w[1];
      for (int j = 0; j < h3dt_pkg::COORD_BITS; j++) begin
        for (int k = 1; k < h3dt_pkg::COORD_BITS; k++) begin
          if (k > j && k < int'(levels_i)) begin
            g[j] = g[j] ^ w[2][k];
          end
        end
      end
      w[0] = w[0] ^ g;
      w[1] = w[1] ^ g;
      w[2] = w[2] ^ g;
    end
    res_d.out_x = w[0];
    res_d.out_y = w[1];
    res_d.out_z = w[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

FILE: rtl/hilbert_3d_transpose.sv
// Top level of the pipelined three-axis curve transform between transpose form and axes.
//
//   channel   handshake          payload
//   command   start / busy       cmd_i    (action, coord_x, coord_y, coord_z)
//   result    done_o             result_o (out_x, out_y, out_z)
//   config    APB psel/penable   paddr, pwdata, prdata
//
// One beat is taken every cycle; busy stays low.
// Each beat passes through an entry stage, one stage per bit level above the lowest,
// and an exit stage.
// Reset clears the valid bits of every stage and sets the level count to eight.
// The receiver cannot stall, so the pipeline never holds; each result shows for one cycle.
`timescale 1ns / 1ps
`include "hilbert_3d_transpose_defines.svh"

module hilbert_3d_transpose (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  h3dt_pkg::cmd_t              cmd_i,
  output logic                        done_o,
  output h3dt_pkg::res_t              result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [h3dt_pkg::ADDR_W-1:0] paddr,
  input  logic [h3dt_pkg::DATA_W-1:0] pwdata,
  output logic [h3dt_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int Stages  = h3dt_pkg::COORD_BITS;
  localparam int Latency = h3dt_pkg::COORD_BITS + 1;

  logic [h3dt_pkg::CFG_W-1:0] levels;
  logic [Stages-1:0]          stg_valid;
  h3dt_pkg::work_t            stg_data [Stages];

  assign busy = 1'b0;

  h3dt_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .levels_o (levels)
  );

  h3dt_pre u_pre (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start && !busy),
    .cmd_i    (cmd_i),
    .levels_i (levels),
    .valid_o  (stg_valid[0]),
    .data_o   (stg_data[0])
  );

  for (genvar j = 0; j < Stages - 1; j++) begin : g_level
    h3dt_level #(
      .LEVEL (j)
    ) u_level (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (stg_valid[j]),
      .data_i   (stg_data[j]),
      .levels_i (levels),
      .valid_o  (stg_valid[j+1]),
      .data_o   (stg_data[j+1])
    );
  end

  h3dt_post u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (stg_valid[Stages-1]),
    .data_i   (stg_data[Stages-1]),
    .levels_i (levels),
    .valid_o  (done_o),
    .result_o (result_o)
  );

  `H3DT_ASSERT(a_done_follows_start, clk_i, rst_ni, done_o |-> $past(start, Latency))
  `H3DT_ASSERT(a_done_from_last_level, clk_i, rst_ni, done_o |-> $past(stg_valid[Stages-1]))
  `H3DT_ASSERT(a_levels_nonzero, clk_i, rst_ni, levels != '0)

endmodule
